FILE: hw/rtl/kpmd_pkg.sv
// ----------------------------------------------------------------------------
// kpmd_pkg
// shared types and constants for the keyed pair match and difference block
// ----------------------------------------------------------------------------
package kpmd_pkg;

   localparam int TABLE_DEPTH = 1024;
   localparam int IDX_W       = $clog2(TABLE_DEPTH);
   localparam int FILL_W      = $clog2(TABLE_DEPTH + 1);
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam int REF_CNT_W   = 11;
   localparam int REF_CNT_MAX = 2047;

   localparam logic KIND_DIFF  = 1'b0;
   localparam logic KIND_COUNT = 1'b1;

   typedef enum logic [1:0] {
      MODE_LOAD  = 2'd0,
      MODE_MATCH = 2'd1,
      MODE_END   = 2'd2
   } mode_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_POST
   } state_type;

   typedef struct packed {
      mode_type           mode;
      logic [15:0]        first_node;
      logic [15:0]        second_node;
      logic signed [31:0] edge_weight;
   } cmd_type;

   typedef struct packed {
      logic [15:0]        key_first;
      logic [15:0]        key_second;
      logic signed [31:0] weight;
   } entry_type;

   typedef struct packed {
      logic                 kind;
      logic [15:0]          key_first;
      logic [15:0]          key_second;
      logic signed [31:0]   weight_difference;
      logic [15:0]          unmatched_compared;
      logic [REF_CNT_W-1:0] unmatched_reference;
   } rsp_type;

   typedef struct packed {
      logic    push;
      cmd_type cmd;
   } q_wr_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

endpackage

FILE: hw/rtl/kpmd_front.sv
// ----------------------------------------------------------------------------
// kpmd_front
// accepts input transactions, drops those that cannot act and queues the rest
// ----------------------------------------------------------------------------
module kpmd_front (
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [1:0]             req_tuser,
   input  logic [63:0]            req_tdata,
   input  kpmd_pkg::q_status_type q_status,
   output kpmd_pkg::q_wr_type     q_wr
);

   logic keep;

   always_comb begin
      unique case (req_tuser)
         kpmd_pkg::MODE_LOAD:  keep = 1'b1;
         kpmd_pkg::MODE_END:   keep = 1'b1;
         // excluded compared key never matches and is not counted
         kpmd_pkg::MODE_MATCH: keep = (req_tdata[15:0] != 16'd0);
         default:              keep = 1'b0;
      endcase
   end

   assign req_tready              = !q_status.full;
   assign q_wr.push               = req_tvalid && req_tready && keep;
   assign q_wr.cmd.mode           = kpmd_pkg::mode_type'(req_tuser);
   assign q_wr.cmd.first_node     = req_tdata[15:0];
   assign q_wr.cmd.second_node    = req_tdata[31:16];
   assign q_wr.cmd.edge_weight    = req_tdata[63:32];

endmodule

FILE: hw/rtl/kpmd_queue.sv
// ----------------------------------------------------------------------------
// kpmd_queue
// short command queue between the front and back parts
// ----------------------------------------------------------------------------
module kpmd_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  kpmd_pkg::q_wr_type     q_wr,
   input  logic                   pop,
   output kpmd_pkg::cmd_type      head,
   output kpmd_pkg::q_status_type q_status
);

   kpmd_pkg::cmd_type                  slot_ff [kpmd_pkg::QUEUE_DEPTH];
   logic [kpmd_pkg::QPTR_W-1:0]        wr_ptr_ff, wr_ptr_in;
   logic [kpmd_pkg::QPTR_W-1:0]        rd_ptr_ff, rd_ptr_in;
   logic [kpmd_pkg::QCNT_W-1:0]        count_ff, count_in;
   logic                               do_push, do_pop;

   assign q_status.full  = (count_ff == kpmd_pkg::QCNT_W'(kpmd_pkg::QUEUE_DEPTH));
   assign q_status.empty = (count_ff == '0);
   assign do_push        = q_wr.push && !q_status.full;
   assign do_pop         = pop && !q_status.empty;
   assign head           = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == kpmd_pkg::QPTR_W'(kpmd_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == kpmd_pkg::QPTR_W'(kpmd_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= q_wr.cmd;
      end
   end

endmodule

FILE: hw/rtl/kpmd_back.sv
// ----------------------------------------------------------------------------
// kpmd_back
// reference table, match scan, counters and the result register
// ----------------------------------------------------------------------------
module kpmd_back (
   input  logic                   clock,
   input  logic                   reset,
   input  kpmd_pkg::cmd_type      head,
   input  kpmd_pkg::q_status_type q_status,
   output logic                   pop,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output kpmd_pkg::rsp_type      rsp_data
);

   localparam int IW = kpmd_pkg::IDX_W;
   localparam int FW = kpmd_pkg::FILL_W;

   kpmd_pkg::entry_type       ent_mem  [kpmd_pkg::TABLE_DEPTH];
   logic                      cons_mem [kpmd_pkg::TABLE_DEPTH];

   kpmd_pkg::state_type       state_ff, state_in;
   logic [FW-1:0]             fill_ff, fill_in;
   logic [FW-1:0]             live_ff, live_in;
   logic [15:0]               miss_ff, miss_in;
   logic [FW-1:0]             rd_idx_ff, rd_idx_in;
   logic                      chk_vld_ff, chk_vld_in;
   logic [IW-1:0]             chk_idx_ff, chk_idx_in;
   kpmd_pkg::cmd_type         cur_ff, cur_in;
   kpmd_pkg::rsp_type         pend_ff, pend_in;
   logic                      rsp_vld_ff, rsp_vld_in;
   kpmd_pkg::rsp_type         rsp_ff, rsp_in;
   kpmd_pkg::entry_type       ent_rd_ff;
   logic                      cons_rd_ff;

   logic                      ent_we, cons_we, cons_wd;
   logic [IW-1:0]             wr_addr;
   kpmd_pkg::entry_type       ent_wd;
   logic                      hit;
   logic signed [32:0]        diff;
   logic signed [31:0]        diff_sat;
   logic [FW+kpmd_pkg::REF_CNT_W-1:0] live_ext;
   logic [kpmd_pkg::REF_CNT_W-1:0]    live_sat;
   logic                      out_free;

   assign hit = chk_vld_ff && !cons_rd_ff &&
                (ent_rd_ff.key_first == cur_ff.first_node) &&
                (ent_rd_ff.key_second == cur_ff.second_node);

   // exact difference in 33 bits, then clamp to the 32-bit range
   assign diff     = {cur_ff.edge_weight[31], cur_ff.edge_weight} -
                     {ent_rd_ff.weight[31], ent_rd_ff.weight};
   assign diff_sat = (diff[32] != diff[31]) ?
                     (diff[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF) : diff[31:0];

   assign live_ext = (FW + kpmd_pkg::REF_CNT_W)'(live_ff);
   assign live_sat = (live_ext > (FW + kpmd_pkg::REF_CNT_W)'(kpmd_pkg::REF_CNT_MAX)) ?
                     kpmd_pkg::REF_CNT_W'(kpmd_pkg::REF_CNT_MAX) :
                     live_ext[kpmd_pkg::REF_CNT_W-1:0];

   assign out_free = !rsp_vld_ff || rsp_ready;

   always_comb begin
      state_in   = state_ff;
      fill_in    = fill_ff;
      live_in    = live_ff;
      miss_in    = miss_ff;
      rd_idx_in  = rd_idx_ff;
      chk_vld_in = 1'b0;
      chk_idx_in = chk_idx_ff;
      cur_in     = cur_ff;
      pend_in    = pend_ff;
      rsp_vld_in = rsp_vld_ff && !rsp_ready;
      rsp_in     = rsp_ff;
      pop        = 1'b0;
      ent_we     = 1'b0;
      cons_we    = 1'b0;
      cons_wd    = 1'b0;
      wr_addr    = fill_ff[IW-1:0];
      ent_wd.key_first  = head.first_node;
      ent_wd.key_second = head.second_node;
      ent_wd.weight     = head.edge_weight;

      unique case (state_ff)
         kpmd_pkg::ST_IDLE: begin
            if (!q_status.empty) begin
               pop = 1'b1;
               unique case (head.mode)
                  kpmd_pkg::MODE_LOAD: begin
                     // table full: the entry is dropped
                     if (fill_ff < FW'(kpmd_pkg::TABLE_DEPTH)) begin
                        ent_we  = 1'b1;
                        cons_we = 1'b1;
                        fill_in = fill_ff + 1'b1;
                        if (head.first_node != 16'd0) begin
                           live_in = live_ff + 1'b1;
                        end
                     end
                  end
                  kpmd_pkg::MODE_MATCH: begin
                     cur_in    = head;
                     rd_idx_in = '0;
                     state_in  = kpmd_pkg::ST_SCAN;
                  end
                  kpmd_pkg::MODE_END: begin
                     pend_in                     = '0;
                     pend_in.kind                = kpmd_pkg::KIND_COUNT;
                     pend_in.unmatched_compared  = miss_ff;
                     pend_in.unmatched_reference = live_sat;
                     fill_in  = '0;
                     live_in  = '0;
                     miss_in  = '0;
                     state_in = kpmd_pkg::ST_POST;
                  end
                  default: ;
               endcase
            end
         end
         kpmd_pkg::ST_SCAN: begin
            if (hit) begin
               cons_we  = 1'b1;
               cons_wd  = 1'b1;
               wr_addr  = chk_idx_ff;
               if (live_ff != '0) begin
                  live_in = live_ff - 1'b1;
               end
               pend_in.kind                = kpmd_pkg::KIND_DIFF;
               pend_in.key_first           = cur_ff.first_node;
               pend_in.key_second          = cur_ff.second_node;
               pend_in.weight_difference   = diff_sat;
               pend_in.unmatched_compared  = '0;
               pend_in.unmatched_reference = '0;
               state_in = kpmd_pkg::ST_POST;
            end else if (rd_idx_ff < fill_ff) begin
               // one table read a cycle, checked in the cycle after
               chk_vld_in = 1'b1;
               chk_idx_in = rd_idx_ff[IW-1:0];
               rd_idx_in  = rd_idx_ff + 1'b1;
            end else if (!chk_vld_ff) begin
               if (miss_ff != 16'hFFFF) begin
                  miss_in = miss_ff + 1'b1;
               end
               state_in = kpmd_pkg::ST_IDLE;
            end
         end
         kpmd_pkg::ST_POST: begin
            if (out_free) begin
               rsp_vld_in = 1'b1;
               rsp_in     = pend_ff;
               state_in   = kpmd_pkg::ST_IDLE;
            end
         end
         default: state_in = kpmd_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= kpmd_pkg::ST_IDLE;
         fill_ff    <= '0;
         live_ff    <= '0;
         miss_ff    <= '0;
         rd_idx_ff  <= '0;
         chk_vld_ff <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         fill_ff    <= fill_in;
         live_ff    <= live_in;
         miss_ff    <= miss_in;
         rd_idx_ff  <= rd_idx_in;
         chk_vld_ff <= chk_vld_in;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      chk_idx_ff <= chk_idx_in;
      cur_ff     <= cur_in;
      pend_ff    <= pend_in;
      rsp_ff     <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (ent_we) begin
         ent_mem[wr_addr] <= ent_wd;
      end
      ent_rd_ff <= ent_mem[rd_idx_ff[IW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (cons_we) begin
         cons_mem[wr_addr] <= cons_wd;
      end
      cons_rd_ff <= cons_mem[rd_idx_ff[IW-1:0]];
   end

   assign rsp_valid = rsp_vld_ff;
   assign rsp_data  = rsp_ff;

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FW'(kpmd_pkg::TABLE_DEPTH))
      else $error("table fill beyond depth");

   a_live_bound: assert property (@(posedge clock) disable iff (reset)
      live_ff <= fill_ff)
      else $error("live count exceeds fill");

   a_check_in_range: assert property (@(posedge clock) disable iff (reset)
      chk_vld_ff |-> (FW'(chk_idx_ff) < fill_ff))
      else $error("scan checked an entry beyond the fill");

   a_post_holds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == kpmd_pkg::ST_POST) && !out_free |=> (state_ff == kpmd_pkg::ST_POST))
      else $error("pending result lost while output busy");

endmodule

FILE: hw/rtl/keyed_pair_match_diff_top.sv
// ----------------------------------------------------------------------------
// keyed_pair_match_diff_top
// matches compared edge entries against a loaded reference table by key pair
// ----------------------------------------------------------------------------
// a load is written to the table when the back part pops it from the queue; an end result
// passes the pending and result registers; a compared entry scans until a hit or the fill:
// the scan reads one table entry per cycle through the single memory read port
// a queue of 4 commands lets input be accepted while the scan runs
// reset is synchronous: counters, fill and handshakes clear at once, the table
// is left unwritten and needs no clearing pass
module keyed_pair_match_diff_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [1:0]  req_tuser,  // mode
   input  logic [63:0] req_tdata,  // first_node, second_node, edge_weight
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [0:0]  rsp_tuser,  // kind
   // key_first, key_second, weight_difference, unmatched_compared,
   // unmatched_reference, zero fill
   output logic [95:0] rsp_tdata
);

   kpmd_pkg::q_wr_type     q_wr;
   kpmd_pkg::q_status_type q_status;
   kpmd_pkg::cmd_type      head;
   kpmd_pkg::rsp_type      rsp_data;
   logic                   pop;

   kpmd_front u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .q_status   (q_status),
      .q_wr       (q_wr)
   );

   kpmd_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .q_wr     (q_wr),
      .pop      (pop),
      .head     (head),
      .q_status (q_status)
   );

   kpmd_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head      (head),
      .q_status  (q_status),
      .pop       (pop),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp_data  (rsp_data)
   );

   assign rsp_tuser = rsp_data.kind;
   assign rsp_tdata = {5'd0,
                       rsp_data.unmatched_reference,
                       rsp_data.unmatched_compared,
                       rsp_data.weight_difference,
                       rsp_data.key_second,
                       rsp_data.key_first};

endmodule

FILE: bench/tb_keyed_pair_match_diff_top.sv
// ----------------------------------------------------------------------------
// tb_keyed_pair_match_diff_top
// drives reference loads, compared entries and end markers into the block,
// predicts every matched difference and end-of-set count, checks each
// response field against the prediction with random stalls on both sides
// ----------------------------------------------------------------------------
module tb_keyed_pair_match_diff_top;

   localparam logic [1:0] MODE_UNUSED   = 2'd3;
   localparam int         CYCLE_LIMIT   = 1_000_000;
   localparam int         RANDOM_ITEMS  = 560;
   localparam int         QUIET_AFTER   = 470;
   localparam int         DRAIN_CYCLES  = kpmd_pkg::TABLE_DEPTH + 16;

   typedef struct packed {
      logic [15:0] first;
      logic [15:0] second;
   } node_pair_type;

   class match_scoreboard;
      logic [15:0]        tbl_first  [kpmd_pkg::TABLE_DEPTH];
      logic [15:0]        tbl_second [kpmd_pkg::TABLE_DEPTH];
      logic signed [31:0] tbl_weight [kpmd_pkg::TABLE_DEPTH];
      bit                 tbl_taken  [kpmd_pkg::TABLE_DEPTH];
      int unsigned        fill;
      int unsigned        live_refs;
      int unsigned        missed;
      kpmd_pkg::rsp_type  pending [$];
      int unsigned        errors;

      function new();
         fill      = 0;
         live_refs = 0;
         missed    = 0;
         errors    = 0;
      endfunction

      task report_mismatch(input string msg);
         $display("mismatch at %0t: %s", $realtime, msg);
         errors++;
      endtask

      // works out the response (if any) caused by one accepted transaction
      function void note_request(input logic [1:0] mode, input logic [15:0] first,
                                 input logic [15:0] second,
                                 input logic signed [31:0] weight);
         kpmd_pkg::rsp_type r;
         longint            diff;
         bit                hit;
         r   = '0;
         hit = 1'b0;
         case (mode)
            kpmd_pkg::MODE_LOAD: begin
               // table full: entry dropped
               if (fill < kpmd_pkg::TABLE_DEPTH) begin
                  tbl_first[fill]  = first;
                  tbl_second[fill] = second;
                  tbl_weight[fill] = weight;
                  tbl_taken[fill]  = 1'b0;
                  fill++;
                  if (first != 16'd0)
                     live_refs++;
               end
            end
            kpmd_pkg::MODE_MATCH: begin
               if (first != 16'd0) begin
                  for (int i = 0; i < fill && !hit; i++) begin
                     if (!tbl_taken[i] && tbl_first[i] == first && tbl_second[i] == second) begin
                        hit  = 1'b1;
                        diff = longint'(weight) - longint'(tbl_weight[i]);
                        if (diff > longint'(32'sh7FFF_FFFF))
                           diff = longint'(32'sh7FFF_FFFF);
                        if (diff < -longint'(64'h8000_0000))
                           diff = -longint'(64'h8000_0000);
                        tbl_taken[i] = 1'b1;
                        if (live_refs > 0)
                           live_refs--;
                        r.kind              = kpmd_pkg::KIND_DIFF;
                        r.key_first         = first;
                        r.key_second        = second;
                        r.weight_difference = 32'(diff);
                        pending.push_back(r);
                     end
                  end
                  if (!hit && missed < 65535)
                     missed++;
               end
            end
            kpmd_pkg::MODE_END: begin
               r.kind                = kpmd_pkg::KIND_COUNT;
               r.unmatched_compared  = 16'(missed);
               r.unmatched_reference = (live_refs > kpmd_pkg::REF_CNT_MAX) ?
                                       kpmd_pkg::REF_CNT_W'(kpmd_pkg::REF_CNT_MAX) :
                                       kpmd_pkg::REF_CNT_W'(live_refs);
               pending.push_back(r);
               fill      = 0;
               live_refs = 0;
               missed    = 0;
            end
            default: ;
         endcase
      endfunction

      task compare_field(input string name, input logic [31:0] got, input logic [31:0] want);
         if (got !== want)
            report_mismatch($sformatf("%s got %h want %h", name, got, want));
      endtask

      task check_result(input logic kind, input logic [95:0] data);
         kpmd_pkg::rsp_type want;
         if (pending.size() == 0) begin
            report_mismatch($sformatf("unexpected response kind %b data %h", kind, data));
         end else begin
            want = pending.pop_front();
            compare_field("kind", 32'(kind), 32'(want.kind));
            compare_field("key_first", 32'(data[15:0]), 32'(want.key_first));
            compare_field("key_second", 32'(data[31:16]), 32'(want.key_second));
            compare_field("weight_difference", data[63:32], want.weight_difference);
            compare_field("unmatched_compared", 32'(data[79:64]), 32'(want.unmatched_compared));
            compare_field("unmatched_reference", 32'(data[90:80]),
                          32'(want.unmatched_reference));
            compare_field("zero fill", 32'(data[95:91]), 32'd0);
         end
      endtask
   endclass

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [1:0]  req_tuser;   // mode
   logic [63:0] req_tdata;   // first_node, second_node, edge_weight
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [0:0]  rsp_tuser;   // kind
   // key_first, key_second, weight_difference, unmatched_compared,
   // unmatched_reference, zero fill
   logic [95:0] rsp_tdata;

   match_scoreboard sb;
   bit              quiet = 1'b0;
   int              stall_left = 0;
   int unsigned     cycle_count = 0;

   keyed_pair_match_diff_top u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tuser  (rsp_tuser),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      clock = 1'b1;
      #6;
      clock = 1'b0;
      #6;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   // receiver stalls in bursts
   always @(negedge clock) begin
      if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_tready <= 1'b0;
      end else if (!quiet && !reset && $urandom_range(0, 7) == 0) begin
         stall_left <= $urandom_range(0, 16);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         sb.check_result(rsp_tuser[0], rsp_tdata);
   end

   // presents one transaction and returns at the edge that accepts it
   task automatic send_item(input logic [1:0] mode, input logic [15:0] first,
                            input logic [15:0] second, input logic [31:0] weight);
      @(negedge clock);
      if (!quiet && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 17)) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= mode;
      req_tdata  <= {weight, second, first};
      do @(posedge clock); while (!req_tready);
      sb.note_request(mode, first, second, weight);
   endtask

   function automatic node_pair_type pick_pair();
      node_pair_type p;
      p.first  = ($urandom_range(0, 15) == 0) ? 16'd0 : 16'($urandom);
      p.second = 16'($urandom);
      return p;
   endfunction

   function automatic logic [31:0] pick_weight();
      case ($urandom_range(0, 11))
         0:       return 32'h7FFF_FFFF;
         1:       return 32'h8000_0000;
         2:       return 32'h0000_0000;
         3:       return 32'hFFFF_FFFF;
         default: return $urandom;
      endcase
   endfunction

   initial begin
      node_pair_type key;
      node_pair_type set_keys [$];
      int unsigned   stim_count;
      int unsigned   set_size;
      int unsigned   loads_left;
      int unsigned   compares_left;
      int unsigned   roll;

      sb         = new();
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tuser  = '0;
      req_tdata  = '0;
      stim_count = 0;
      repeat (10) @(negedge clock);
      reset <= 1'b0;

      // directed: empty set, duplicates, excluded keys, saturation both ways
      send_item(kpmd_pkg::MODE_END, 16'h0000, 16'h0000, 32'h0000_0000);
      send_item(kpmd_pkg::MODE_LOAD, 16'h0001, 16'h0002, 32'h0001_0000);
      send_item(kpmd_pkg::MODE_LOAD, 16'h0001, 16'h0002, 32'h0002_0000);
      send_item(kpmd_pkg::MODE_LOAD, 16'h0000, 16'h0005, 32'h0000_0007);
      send_item(kpmd_pkg::MODE_LOAD, 16'hFFFF, 16'hFFFF, 32'h7FFF_FFFF);
      send_item(kpmd_pkg::MODE_LOAD, 16'h8000, 16'h0000, 32'h8000_0000);
      send_item(MODE_UNUSED, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
      send_item(kpmd_pkg::MODE_MATCH, 16'h0001, 16'h0002, 32'h0003_0000);
      send_item(kpmd_pkg::MODE_MATCH, 16'h0001, 16'h0002, 32'h0000_0000);
      send_item(kpmd_pkg::MODE_MATCH, 16'h0001, 16'h0002, 32'h0000_0005);
      send_item(kpmd_pkg::MODE_MATCH, 16'h0000, 16'h0005, 32'h0000_0007);
      send_item(kpmd_pkg::MODE_MATCH, 16'hFFFF, 16'hFFFF, 32'h8000_0000);
      send_item(kpmd_pkg::MODE_MATCH, 16'h8000, 16'h0000, 32'h7FFF_FFFF);
      send_item(kpmd_pkg::MODE_MATCH, 16'h0003, 16'h0004, 32'h0000_0000);
      send_item(kpmd_pkg::MODE_END, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
      send_item(kpmd_pkg::MODE_LOAD, 16'h0009, 16'h0009, 32'h1234_5678);
      send_item(kpmd_pkg::MODE_LOAD, 16'hAAAA, 16'h5555, 32'hFFFF_FFFF);
      send_item(kpmd_pkg::MODE_END, 16'h0000, 16'h0000, 32'h0000_0000);

      // random sets: mostly loads first, then compares mostly drawn from loaded keys
      while (stim_count < RANDOM_ITEMS) begin
         set_size      = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 200)
                                                     : $urandom_range(1, 40);
         // shrink the last set to half the remaining item budget, plus one
         if (2 * set_size > RANDOM_ITEMS - stim_count)
            set_size = (RANDOM_ITEMS - stim_count) / 2 + 1;
         loads_left    = set_size;
         compares_left = set_size + $urandom_range(0, 8);
         set_keys.delete();
         while (loads_left + compares_left > 0) begin
            roll = $urandom_range(0, 99);
            key  = pick_pair();
            if (roll < 3) begin
               send_item(MODE_UNUSED, key.first, key.second, pick_weight());
            end else if (loads_left > 0 && (roll < 75 || compares_left == 0)) begin
               if (set_keys.size() > 0 && $urandom_range(0, 3) == 0)
                  key = set_keys[$urandom_range(0, set_keys.size() - 1)];
               send_item(kpmd_pkg::MODE_LOAD, key.first, key.second, pick_weight());
               set_keys.push_back(key);
               loads_left--;
               stim_count++;
            end else begin
               if (set_keys.size() > 0 && $urandom_range(0, 9) < 7)
                  key = set_keys[$urandom_range(0, set_keys.size() - 1)];
               send_item(kpmd_pkg::MODE_MATCH, key.first, key.second, pick_weight());
               compares_left--;
               stim_count++;
            end
            quiet = (stim_count > QUIET_AFTER);
         end
         key = pick_pair();
         send_item(kpmd_pkg::MODE_END, key.first, key.second, pick_weight());
         stim_count++;
         quiet = (stim_count > QUIET_AFTER);
      end

      @(negedge clock);
      req_tvalid <= 1'b0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.errors == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("Test completed with failures");
      $finish;
   end

endmodule
